// File: rtl/core/tmc_pkg.sv
// types, microcode program and lookup functions for the thermal monitor controller
package tmc_pkg;

    // operating modes, coded as they appear on the mode output
    typedef enum logic [2:0] {
        MODE_STARTUP  = 3'd0,
        MODE_OK       = 3'd1,
        MODE_CHECKING = 3'd2,
        MODE_WARNING  = 3'd3,
        MODE_DANGER   = 3'd4,
        MODE_OFF      = 3'd5
    } mode_t;

    // sub-phases of the danger sequence
    typedef enum logic [1:0] {
        PH_WINDOW = 2'd0,
        PH_COOL   = 2'd1,
        PH_BLINK  = 2'd2
    } phase_t;

    // configuration register indexes
    localparam logic [2:0] CFG_OK_LIMIT     = 3'd0;
    localparam logic [2:0] CFG_DANGER_LIMIT = 3'd1;
    localparam logic [2:0] CFG_SAMPLES      = 3'd2;
    localparam logic [2:0] CFG_WINDOW_MS    = 3'd3;
    localparam logic [2:0] CFG_COOLING_MS   = 3'd4;
    localparam logic [2:0] CFG_BLINK_MS     = 3'd5;

    // micro-operations
    typedef enum logic [2:0] {
        UOP_NOP,
        UOP_DANGER,
        UOP_SAMPLE,
        UOP_DIV_INIT,
        UOP_DIV,
        UOP_CLASSIFY,
        UOP_OUT
    } uop_t;

    // what a step waits for before it fires
    typedef enum logic [1:0] {
        WAIT_NONE,
        WAIT_IN,
        WAIT_OUT
    } wait_t;

    // multiplier operand selection
    typedef enum logic [2:0] {
        MS_OK_FS,
        MS_DG_FS,
        MS_SCALE_N,
        MS_LAST_500,
        MS_SUM_500,
        MS_FS_N
    } mul_sel_t;

    // multiplier result destination
    typedef enum logic [2:0] {
        MD_NONE,
        MD_PROD,
        MD_OKS,
        MD_DGS,
        MD_S500
    } mul_dst_t;

    // jump conditions
    typedef enum logic [1:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_NO_EVAL,
        COND_CNT_NZ
    } cond_t;

    typedef logic [3:0] step_t;

    typedef struct packed {
        uop_t     op;
        wait_t    wait_on;
        mul_sel_t msel;
        mul_dst_t mdst;
        cond_t    cond;
        step_t    target;
    } ucw_t;

    localparam step_t STEP_WAIT     = 4'd0;
    localparam step_t STEP_OK_FS    = 4'd1;
    localparam step_t STEP_OK_N     = 4'd2;
    localparam step_t STEP_DG_FS    = 4'd3;
    localparam step_t STEP_DG_N     = 4'd4;
    localparam step_t STEP_LAST_500 = 4'd5;
    localparam step_t STEP_DANGER   = 4'd6;
    localparam step_t STEP_SAMPLE   = 4'd7;
    localparam step_t STEP_SUM_500  = 4'd8;
    localparam step_t STEP_DIV_INIT = 4'd9;
    localparam step_t STEP_DIV      = 4'd10;
    localparam step_t STEP_CLASSIFY = 4'd11;
    localparam step_t STEP_OUT      = 4'd12;

    function automatic ucw_t cw(uop_t op, wait_t wo, mul_sel_t ms, mul_dst_t md,
                                cond_t cond, step_t target);
        ucw_t w;
        w.op      = op;
        w.wait_on = wo;
        w.msel    = ms;
        w.mdst    = md;
        w.cond    = cond;
        w.target  = target;
        return w;
    endfunction

    // control store: one control word per step
    function automatic ucw_t ucode(step_t step);
        ucw_t w;
        unique case (step)
            STEP_WAIT:     w = cw(UOP_NOP, WAIT_IN, MS_OK_FS, MD_NONE, COND_NEVER, STEP_WAIT);
            STEP_OK_FS:    w = cw(UOP_NOP, WAIT_NONE, MS_OK_FS, MD_PROD, COND_NEVER, STEP_WAIT);
            STEP_OK_N:     w = cw(UOP_NOP, WAIT_NONE, MS_SCALE_N, MD_OKS, COND_NEVER, STEP_WAIT);
            STEP_DG_FS:    w = cw(UOP_NOP, WAIT_NONE, MS_DG_FS, MD_PROD, COND_NEVER, STEP_WAIT);
            STEP_DG_N:     w = cw(UOP_NOP, WAIT_NONE, MS_SCALE_N, MD_DGS, COND_NEVER, STEP_WAIT);
            STEP_LAST_500: w = cw(UOP_NOP, WAIT_NONE, MS_LAST_500, MD_S500, COND_NEVER,
                                  STEP_WAIT);
            STEP_DANGER:   w = cw(UOP_DANGER, WAIT_NONE, MS_OK_FS, MD_NONE, COND_NEVER,
                                  STEP_WAIT);
            STEP_SAMPLE:   w = cw(UOP_SAMPLE, WAIT_NONE, MS_OK_FS, MD_NONE, COND_NO_EVAL,
                                  STEP_OUT);
            STEP_SUM_500:  w = cw(UOP_NOP, WAIT_NONE, MS_SUM_500, MD_S500, COND_NEVER,
                                  STEP_WAIT);
            STEP_DIV_INIT: w = cw(UOP_DIV_INIT, WAIT_NONE, MS_FS_N, MD_PROD, COND_NEVER,
                                  STEP_WAIT);
            STEP_DIV:      w = cw(UOP_DIV, WAIT_NONE, MS_OK_FS, MD_NONE, COND_CNT_NZ, STEP_DIV);
            STEP_CLASSIFY: w = cw(UOP_CLASSIFY, WAIT_NONE, MS_OK_FS, MD_NONE, COND_NEVER,
                                  STEP_WAIT);
            STEP_OUT:      w = cw(UOP_OUT, WAIT_OUT, MS_OK_FS, MD_NONE, COND_ALWAYS, STEP_WAIT);
            default:       w = cw(UOP_NOP, WAIT_NONE, MS_OK_FS, MD_NONE, COND_ALWAYS,
                                  STEP_WAIT);
        endcase
        return w;
    endfunction

    // seven-segment patterns, segments a..g in bits 0..6
    function automatic logic [6:0] digit_pattern(logic [3:0] d);
        logic [6:0] p;
        unique case (d)
            4'd0:    p = 7'h3F;
            4'd1:    p = 7'h06;
            4'd2:    p = 7'h5B;
            4'd3:    p = 7'h4F;
            4'd4:    p = 7'h66;
            4'd5:    p = 7'h6D;
            4'd6:    p = 7'h7D;
            4'd7:    p = 7'h07;
            4'd8:    p = 7'h7F;
            4'd9:    p = 7'h6F;
            default: p = 7'h00;
        endcase
        return p;
    endfunction

    function automatic logic [11:0] at_least_one(logic [11:0] v);
        return (v == 12'd0) ? 12'd1 : v;
    endfunction

endpackage

// File: rtl/core/thermal_monitor_controller.sv
// thermal monitor controller: microcoded sequencer over a shared multiplier and serial divider
//
// One input beat is one millisecond tick: sample_valid and sample carry a converter
// reading on timer events, button_edge and the three button levels carry the buttons.
// Every input beat yields exactly one output beat with mode, lamp controls and the two
// seven-segment digits; display_update marks beats on which the digits were refreshed.
// Limits, samples per average and the three danger durations are written through the
// cfg channel (cfg_index selects the register), which is always ready; write only while
// no tick is in flight.
// Each tick walks a short program: a tick without evaluation jumps from the sampling step
// to the output step; an evaluating tick also runs the one-bit-per-cycle restoring
// divider, which steps through the CW-bit dividend for the average. The next input beat
// is taken as soon as the result sits in the output register, so a stalled receiver
// holds at most one finished result and blocks the sequencer only when the next result
// is ready.
// Reset puts the block in STARTUP with sums cleared, digits blank, no output pending and
// the configuration at its default values.
module thermal_monitor_controller
    import tmc_pkg::*;
#(
    parameter int SAMPLE_BITS = 12
)
(
    input  logic        clk,
    input  logic        rst_n,
    // tick channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        sample_valid,
    input  logic [11:0] sample,
    input  logic        button_edge,
    input  logic        start_button,
    input  logic        restart_button,
    input  logic        cool_button,
    // result channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  mode,
    output logic        green_led,
    output logic        orange_led,
    output logic        red_led,
    output logic        blink_run,
    output logic        blink_orange,
    output logic        blink_red,
    output logic [6:0]  tens_segments,
    output logic [6:0]  ones_segments,
    output logic        display_update,
    // configuration channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [11:0] cfg_data
);

    localparam int SW  = (SAMPLE_BITS < 12) ? SAMPLE_BITS : 12;
    localparam int AW  = 9 + SAMPLE_BITS;
    localparam int BW  = (SAMPLE_BITS > 9) ? SAMPLE_BITS : 9;
    localparam int PW  = AW + BW;
    localparam int CW  = (13 + SAMPLE_BITS > 25) ? 13 + SAMPLE_BITS : 25;
    localparam int DVW = SAMPLE_BITS + 4;
    localparam int DCW = $clog2(CW);
    localparam logic [SAMPLE_BITS-1:0] FS = '1;

    // configuration
    logic [8:0]  ok_limit_reg, danger_limit_reg;
    logic [3:0]  samples_reg;
    logic [11:0] window_reg, cooling_reg, blink_reg;

    // sequencer
    step_t       ustep_reg, ustep_next;
    ucw_t        ucw;
    logic        fire;
    logic        out_free;

    // captured tick
    logic        smp_valid_reg;
    logic [11:0] smp_reg;
    logic        edge_reg, start_reg, restart_reg, cool_reg;

    // controller state
    mode_t       mode_reg, mode_next;
    phase_t      phase_reg, phase_next;
    logic [11:0] ms_cnt_reg, ms_cnt_next;
    logic [3:0]  count_reg, count_next;
    logic [15:0] sum_reg, sum_next;
    logic [15:0] last_sum_reg, last_sum_next;
    logic [13:0] seg_reg, seg_next;
    logic        upd_reg, upd_next;

    // datapath
    logic [AW-1:0]  mul_a;
    logic [BW-1:0]  mul_b;
    logic [PW-1:0]  mul_p;
    logic [CW-1:0]  mul_res;
    logic [CW-1:0]  prod_reg, ok_scaled_reg, dg_scaled_reg, s500_reg;
    logic [CW-1:0]  dq_reg, dq_next;
    logic [DVW-1:0] rem_reg, rem_next;
    logic [DVW-1:0] divisor;
    logic [DCW-1:0] dcnt_reg, dcnt_next;
    logic [3:0]     r10_reg, r10_next;
    logic [3:0]     tens_reg, tens_next;
    logic           tens_big_reg, tens_big_next;

    logic [3:0]     n_eff;
    logic           eval_needed;
    logic           jump;

    // output register
    logic        out_valid_reg;
    logic [2:0]  out_mode_reg;
    logic [5:0]  out_lamps_reg;
    logic [13:0] out_seg_reg;
    logic        out_upd_reg;
    logic [5:0]  lamps;

    assign cfg_ready = 1'b1;
    assign n_eff     = (samples_reg == 4'd0) ? 4'd1 : samples_reg;
    assign divisor   = prod_reg[DVW-1:0];
    assign ucw       = ucode(ustep_reg);
    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (ucw.wait_on != WAIT_IN);

    assign eval_needed = smp_valid_reg && (mode_reg != MODE_STARTUP) &&
                         (mode_reg != MODE_OFF) && (count_reg >= n_eff);

    // ---------------- sequencer ----------------
    always_comb
    begin
        case (ucw.wait_on)
            WAIT_IN:  fire = in_valid;
            WAIT_OUT: fire = out_free;
            default:  fire = 1'b1;
        endcase

        unique case (ucw.cond)
            COND_ALWAYS:  jump = 1'b1;
            COND_NO_EVAL: jump = !eval_needed;
            COND_CNT_NZ:  jump = (dcnt_reg != '0);
            default:      jump = 1'b0;
        endcase

        if (!fire)
        begin
            ustep_next = ustep_reg;
        end
        else if (jump)
        begin
            ustep_next = ucw.target;
        end
        else
        begin
            ustep_next = step_t'(ustep_reg + 4'd1);
        end
    end

    // ---------------- shared multiplier ----------------
    always_comb
    begin
        unique case (ucw.msel)
            MS_OK_FS:
            begin
                mul_a = AW'(ok_limit_reg);
                mul_b = BW'(FS);
            end
            MS_DG_FS:
            begin
                mul_a = AW'(danger_limit_reg);
                mul_b = BW'(FS);
            end
            MS_SCALE_N:
            begin
                mul_a = prod_reg[AW-1:0];
                mul_b = BW'(n_eff);
            end
            MS_LAST_500:
            begin
                mul_a = AW'(last_sum_reg);
                mul_b = BW'(9'd500);
            end
            MS_SUM_500:
            begin
                mul_a = AW'(sum_reg);
                mul_b = BW'(9'd500);
            end
            MS_FS_N:
            begin
                mul_a = AW'(FS);
                mul_b = BW'(n_eff);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p   = mul_a * mul_b;
        mul_res = mul_p[CW-1:0];
    end

    // ---------------- controller and divider ----------------
    always_comb
    begin
        logic [11:0]    cnt_inc;
        logic           last_le_ok;
        logic           le_ok;
        logic           ge_dg;
        logic [16:0]    sum_wide;
        logic [DVW:0]   div_t;
        logic [DVW:0]   div_d;
        logic           qbit;
        logic [4:0]     t10;
        logic           q10;
        logic [4:0]     tens_wide;
        logic [6:0]     tseg;

        mode_next     = mode_reg;
        phase_next    = phase_reg;
        ms_cnt_next   = ms_cnt_reg;
        count_next    = count_reg;
        sum_next      = sum_reg;
        last_sum_next = last_sum_reg;
        seg_next      = seg_reg;
        upd_next      = upd_reg;
        dq_next       = dq_reg;
        rem_next      = rem_reg;
        dcnt_next     = dcnt_reg;
        r10_next      = r10_reg;
        tens_next     = tens_reg;
        tens_big_next = tens_big_reg;

        cnt_inc    = ms_cnt_reg + 12'd1;
        last_le_ok = (s500_reg <= ok_scaled_reg);
        le_ok      = (s500_reg <= ok_scaled_reg);
        ge_dg      = (s500_reg >= dg_scaled_reg);
        sum_wide   = {1'b0, sum_reg} + 17'(smp_reg[SW-1:0]);

        // one restoring step, its quotient bit also fed to a running divide by ten
        div_t     = {rem_reg, dq_reg[CW-1]};
        div_d     = div_t - {1'b0, divisor};
        qbit      = (div_t >= {1'b0, divisor});
        t10       = {r10_reg, qbit};
        q10       = (t10 >= 5'd10);
        tens_wide = {tens_reg, q10};
        tseg      = tens_big_reg ? digit_pattern(4'd0) : digit_pattern(tens_reg);

        if (fire)
        begin
            unique case (ucw.op)
                UOP_NOP:
                begin
                    if (ucw.wait_on == WAIT_IN)
                    begin
                        upd_next = 1'b0;
                    end
                end
                UOP_DANGER:
                begin
                    if (mode_reg == MODE_DANGER)
                    begin
                        unique case (phase_reg)
                            PH_WINDOW:
                            begin
                                if (cool_reg)
                                begin
                                    phase_next  = PH_COOL;
                                    ms_cnt_next = '0;
                                end
                                else if (cnt_inc >= at_least_one(window_reg))
                                begin
                                    mode_next   = MODE_OFF;
                                    phase_next  = PH_WINDOW;
                                    ms_cnt_next = '0;
                                end
                                else
                                begin
                                    ms_cnt_next = cnt_inc;
                                end
                            end
                            PH_COOL:
                            begin
                                if (last_le_ok)
                                begin
                                    mode_next   = MODE_OK;
                                    phase_next  = PH_WINDOW;
                                    ms_cnt_next = '0;
                                end
                                else if (cnt_inc >= at_least_one(cooling_reg))
                                begin
                                    phase_next  = PH_BLINK;
                                    ms_cnt_next = '0;
                                end
                                else
                                begin
                                    ms_cnt_next = cnt_inc;
                                end
                            end
                            default:
                            begin
                                if (cnt_inc >= at_least_one(blink_reg))
                                begin
                                    mode_next   = MODE_OFF;
                                    phase_next  = PH_WINDOW;
                                    ms_cnt_next = '0;
                                end
                                else
                                begin
                                    ms_cnt_next = cnt_inc;
                                end
                            end
                        endcase
                    end
                    // buttons see the mode left by the danger sequence of this tick
                    if (edge_reg)
                    begin
                        if (start_reg)
                        begin
                            if (mode_next == MODE_STARTUP)
                            begin
                                mode_next   = MODE_CHECKING;
                                phase_next  = PH_WINDOW;
                                ms_cnt_next = '0;
                            end
                        end
                        else if (restart_reg && (mode_next == MODE_OFF))
                        begin
                            mode_next   = MODE_CHECKING;
                            phase_next  = PH_WINDOW;
                            ms_cnt_next = '0;
                        end
                    end
                end
                UOP_SAMPLE:
                begin
                    if (smp_valid_reg && !eval_needed && (mode_reg != MODE_STARTUP) &&
                        (mode_reg != MODE_OFF))
                    begin
                        sum_next   = sum_wide[16] ? 16'hFFFF : sum_wide[15:0];
                        count_next = count_reg + 4'd1;
                    end
                end
                UOP_DIV_INIT:
                begin
                    dq_next       = s500_reg;
                    rem_next      = '0;
                    dcnt_next     = DCW'(CW - 1);
                    r10_next      = '0;
                    tens_next     = '0;
                    tens_big_next = 1'b0;
                end
                UOP_DIV:
                begin
                    dq_next   = {dq_reg[CW-2:0], qbit};
                    rem_next  = qbit ? div_d[DVW-1:0] : div_t[DVW-1:0];
                    r10_next  = q10 ? 4'(t10 - 5'd10) : t10[3:0];
                    tens_next = tens_wide[3:0];
                    if (tens_big_reg || (tens_wide > 5'd9))
                    begin
                        tens_big_next = 1'b1;
                    end
                    if (dcnt_reg != '0)
                    begin
                        dcnt_next = dcnt_reg - DCW'(1);
                    end
                end
                UOP_CLASSIFY:
                begin
                    seg_next = {digit_pattern(r10_reg), tseg};
                    if (mode_reg != MODE_DANGER)
                    begin
                        if (ge_dg)
                        begin
                            mode_next   = MODE_DANGER;
                            phase_next  = PH_WINDOW;
                            ms_cnt_next = '0;
                        end
                        else if (!le_ok)
                        begin
                            mode_next = MODE_WARNING;
                        end
                        else
                        begin
                            mode_next = MODE_OK;
                        end
                    end
                    last_sum_next = sum_reg;
                    sum_next      = '0;
                    count_next    = '0;
                    upd_next      = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    // lamp decode: {blink_red, blink_orange, blink_run, red, orange, green}
    always_comb
    begin
        lamps = '0;
        unique case (mode_reg)
            MODE_OK:       lamps[0] = 1'b1;
            MODE_WARNING:  lamps[1] = 1'b1;
            MODE_CHECKING: lamps[4:3] = 2'b11;
            MODE_DANGER:
            begin
                if (phase_reg == PH_COOL)
                begin
                    lamps[2] = 1'b1;
                end
                else
                begin
                    lamps[3] = 1'b1;
                    lamps[5] = 1'b1;
                end
            end
            default:       lamps = '0;
        endcase
    end

    // ---------------- registers with reset ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ustep_reg        <= STEP_WAIT;
            mode_reg         <= MODE_STARTUP;
            phase_reg        <= PH_WINDOW;
            ms_cnt_reg       <= '0;
            count_reg        <= '0;
            sum_reg          <= '0;
            last_sum_reg     <= '0;
            seg_reg          <= '0;
            upd_reg          <= 1'b0;
            out_valid_reg    <= 1'b0;
            ok_limit_reg     <= 9'd35;
            danger_limit_reg <= 9'd46;
            samples_reg      <= 4'd10;
            window_reg       <= 12'd1000;
            cooling_reg      <= 12'd2000;
            blink_reg        <= 12'd500;
        end
        else
        begin
            ustep_reg    <= ustep_next;
            mode_reg     <= mode_next;
            phase_reg    <= phase_next;
            ms_cnt_reg   <= ms_cnt_next;
            count_reg    <= count_next;
            sum_reg      <= sum_next;
            last_sum_reg <= last_sum_next;
            seg_reg      <= seg_next;
            upd_reg      <= upd_next;

            if (fire && (ucw.op == UOP_OUT))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_OK_LIMIT:     ok_limit_reg     <= cfg_data[8:0];
                    CFG_DANGER_LIMIT: danger_limit_reg <= cfg_data[8:0];
                    CFG_SAMPLES:      samples_reg      <= cfg_data[3:0];
                    CFG_WINDOW_MS:    window_reg       <= cfg_data;
                    CFG_COOLING_MS:   cooling_reg      <= cfg_data;
                    CFG_BLINK_MS:     blink_reg        <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge clk)
    begin
        if (fire && (ucw.wait_on == WAIT_IN))
        begin
            smp_valid_reg <= sample_valid;
            smp_reg       <= sample;
            edge_reg      <= button_edge;
            start_reg     <= start_button;
            restart_reg   <= restart_button;
            cool_reg      <= cool_button;
        end

        unique case (ucw.mdst)
            MD_PROD: prod_reg      <= mul_res;
            MD_OKS:  ok_scaled_reg <= mul_res;
            MD_DGS:  dg_scaled_reg <= mul_res;
            MD_S500: s500_reg      <= mul_res;
            default:
            begin
            end
        endcase

        dq_reg       <= dq_next;
        rem_reg      <= rem_next;
        dcnt_reg     <= dcnt_next;
        r10_reg      <= r10_next;
        tens_reg     <= tens_next;
        tens_big_reg <= tens_big_next;

        if (fire && (ucw.op == UOP_OUT))
        begin
            out_mode_reg  <= mode_reg;
            out_lamps_reg <= lamps;
            out_seg_reg   <= seg_reg;
            out_upd_reg   <= upd_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign mode           = out_mode_reg;
    assign green_led      = out_lamps_reg[0];
    assign orange_led     = out_lamps_reg[1];
    assign red_led        = out_lamps_reg[2];
    assign blink_run      = out_lamps_reg[3];
    assign blink_orange   = out_lamps_reg[4];
    assign blink_red      = out_lamps_reg[5];
    assign tens_segments  = out_seg_reg[6:0];
    assign ones_segments  = out_seg_reg[13:7];
    assign display_update = out_upd_reg;

    // ---------------- assertions ----------------
    // an accepted beat always starts the program at its first compute step
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (ustep_reg == STEP_OK_FS))
        else $error("sequencer did not start after an accepted beat");

    // a new result only appears right after the output step fired
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(ustep_reg == STEP_OUT))
        else $error("result valid rose outside the output step");

    // partial remainder stays below the divisor throughout the divide loop
    assert property (@(posedge clk) disable iff (!rst_n)
        (ustep_reg == STEP_DIV) |-> (rem_reg < divisor))
        else $error("divider remainder out of range");

    // classification only follows a sampling event and a finished divide
    assert property (@(posedge clk) disable iff (!rst_n)
        (ustep_reg == STEP_CLASSIFY) |-> (smp_valid_reg && (dcnt_reg == '0)))
        else $error("evaluation reached without a sample or with divide unfinished");

endmodule

// File: test/thermal_monitor_controller_test.sv
// self-checking testbench for the thermal monitor controller: directed ticks, then random phases
module thermal_monitor_controller_test
    import tmc_pkg::*;
();

    localparam int SAMPLE_W = 12;
    localparam longint unsigned FULL_SCALE = (64'd1 << SAMPLE_W) - 64'd1;
    localparam int RANDOM_PHASES = 8;
    localparam int TICKS_PER_PHASE = 150;
    localparam int SETTLE_CYCLES = 60;
    localparam int QUIET_LIMIT = 2000;

    localparam logic [6:0] SEG_OF [10] = '{
        7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
    };

    // ok, danger, samples per average, window, cooling, blink
    localparam int unsigned PLAN [7][6] = '{
        '{35, 46, 4, 8, 6, 3},
        '{0, 0, 1, 1, 1, 1},
        '{511, 511, 15, 20, 10, 5},
        '{100, 300, 2, 0, 0, 0},
        '{40, 45, 0, 5, 12, 4},
        '{200, 100, 3, 10, 10, 10},
        '{60, 80, 15, 4095, 4095, 4095}
    };

    typedef struct packed {
        logic        sample_valid;
        logic [11:0] sample;
        logic        button_edge;
        logic        start_button;
        logic        restart_button;
        logic        cool_button;
    } tick_t;

    typedef struct packed {
        mode_t      mode;
        logic       green_led;
        logic       orange_led;
        logic       red_led;
        logic       blink_run;
        logic       blink_orange;
        logic       blink_red;
        logic [6:0] tens_segments;
        logic [6:0] ones_segments;
        logic       display_update;
    } status_t;

    typedef struct packed {
        tick_t   t;
        logic    typed;
        status_t want;
    } dir_row_t;

    localparam status_t AT_RESET =
        '{MODE_STARTUP, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 7'h00, 7'h00, 1'b0};
    localparam status_t CHECK_BLANK =
        '{MODE_CHECKING, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 7'h00, 7'h00, 1'b0};
    localparam status_t DANGER_FULL =
        '{MODE_DANGER, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 7'h3F, 7'h3F, 1'b1};

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        sample_valid;
    logic [11:0] sample;
    logic        button_edge;
    logic        start_button;
    logic        restart_button;
    logic        cool_button;
    logic        out_valid;
    logic        out_stall;
    logic [2:0]  mode;
    logic        green_led;
    logic        orange_led;
    logic        red_led;
    logic        blink_run;
    logic        blink_orange;
    logic        blink_red;
    logic [6:0]  tens_segments;
    logic [6:0]  ones_segments;
    logic        display_update;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [11:0] cfg_data;

    // predicted configuration
    logic [8:0]  cfg_ok = 9'd35;
    logic [8:0]  cfg_danger = 9'd46;
    logic [3:0]  cfg_per_avg = 4'd10;
    logic [11:0] cfg_window = 12'd1000;
    logic [11:0] cfg_cooling = 12'd2000;
    logic [11:0] cfg_blink = 12'd500;

    // predicted monitor state
    mode_t       mon_mode = MODE_STARTUP;
    phase_t      mon_phase = PH_WINDOW;
    logic [11:0] mon_ms = '0;
    logic [3:0]  mon_count = '0;
    logic [15:0] mon_sum = '0;
    logic [15:0] mon_last = '0;
    logic [13:0] mon_segs = '0;

    status_t readings_due [$];
    int unsigned fails = 0;
    int unsigned burst_left = 0;
    bit gappy = 1'b1;

    thermal_monitor_controller dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic longint unsigned per_average();
        return (cfg_per_avg == 4'd0) ? 64'd1 : 64'(cfg_per_avg);
    endfunction

    function automatic longint unsigned scaled_limit(logic [8:0] lim);
        return 64'(lim) * FULL_SCALE * per_average();
    endfunction

    function automatic bit at_or_below(logic [15:0] sum, logic [8:0] lim);
        return 64'(sum) * 64'd500 <= scaled_limit(lim);
    endfunction

    function automatic logic [11:0] nonzero(logic [11:0] v);
        return (v == 12'd0) ? 12'd1 : v;
    endfunction

    function automatic void enter_mode(mode_t m);
        mon_mode = m;
        mon_phase = PH_WINDOW;
        mon_ms = '0;
    endfunction

    // one millisecond tick of the monitor, returns the status shown after it
    function automatic status_t advance_monitor(tick_t t);
        status_t r;
        logic [16:0] grown;
        longint unsigned shown;
        longint unsigned tens;
        r = '0;
        if (mon_mode == MODE_DANGER)
        begin
            if (mon_phase == PH_WINDOW)
            begin
                if (t.cool_button)
                begin
                    mon_phase = PH_COOL;
                    mon_ms = '0;
                end
                else
                begin
                    mon_ms = mon_ms + 12'd1;
                    if (mon_ms >= nonzero(cfg_window))
                        enter_mode(MODE_OFF);
                end
            end
            else if (mon_phase == PH_COOL)
            begin
                if (at_or_below(mon_last, cfg_ok))
                    enter_mode(MODE_OK);
                else
                begin
                    mon_ms = mon_ms + 12'd1;
                    if (mon_ms >= nonzero(cfg_cooling))
                    begin
                        mon_phase = PH_BLINK;
                        mon_ms = '0;
                    end
                end
            end
            else
            begin
                mon_ms = mon_ms + 12'd1;
                if (mon_ms >= nonzero(cfg_blink))
                    enter_mode(MODE_OFF);
            end
        end

        // start wins over restart on a shared edge
        if (t.button_edge)
        begin
            if (t.start_button)
            begin
                if (mon_mode == MODE_STARTUP)
                    enter_mode(MODE_CHECKING);
            end
            else if (t.restart_button && mon_mode == MODE_OFF)
                enter_mode(MODE_CHECKING);
        end

        if (t.sample_valid && mon_mode != MODE_STARTUP && mon_mode != MODE_OFF)
        begin
            if (64'(mon_count) >= per_average())
            begin
                shown = (64'(mon_sum) * 64'd500) / (FULL_SCALE * per_average());
                tens = shown / 10;
                if (tens > 9)
                    tens = 0;
                mon_segs = {SEG_OF[shown % 10], SEG_OF[tens]};
                if (mon_mode != MODE_DANGER)
                begin
                    if (64'(mon_sum) * 64'd500 >= scaled_limit(cfg_danger))
                        enter_mode(MODE_DANGER);
                    else if (!at_or_below(mon_sum, cfg_ok))
                        mon_mode = MODE_WARNING;
                    else
                        mon_mode = MODE_OK;
                end
                mon_last = mon_sum;
                mon_sum = '0;
                mon_count = '0;
                r.display_update = 1'b1;
            end
            else
            begin
                grown = {1'b0, mon_sum} + {5'b0, t.sample};
                mon_sum = grown[16] ? 16'hFFFF : grown[15:0];
                mon_count = mon_count + 4'd1;
            end
        end

        case (mon_mode)
            MODE_OK: r.green_led = 1'b1;
            MODE_WARNING: r.orange_led = 1'b1;
            MODE_CHECKING:
            begin
                r.blink_run = 1'b1;
                r.blink_orange = 1'b1;
            end
            MODE_DANGER:
            begin
                if (mon_phase == PH_COOL)
                    r.red_led = 1'b1;
                else
                begin
                    r.blink_run = 1'b1;
                    r.blink_red = 1'b1;
                end
            end
            default: ;
        endcase
        r.mode = mon_mode;
        r.tens_segments = mon_segs[6:0];
        r.ones_segments = mon_segs[13:7];
        return r;
    endfunction

    function automatic tick_t tk(bit sv, int smp, bit be, bit st, bit rs, bit cl);
        tick_t t;
        t.sample_valid = sv;
        t.sample = smp[11:0];
        t.button_edge = be;
        t.start_button = st;
        t.restart_button = rs;
        t.cool_button = cl;
        return t;
    endfunction

    task automatic send_tick(tick_t t, bit typed, status_t want);
        status_t guess;
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 30);
            gap = gappy ? $urandom_range(0, 12) : 0;
            if (gap > 0)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        in_valid <= 1'b1;
        sample_valid <= t.sample_valid;
        sample <= t.sample;
        button_edge <= t.button_edge;
        start_button <= t.start_button;
        restart_button <= t.restart_button;
        cool_button <= t.cool_button;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        guess = advance_monitor(t);
        readings_due.push_back(typed ? want : guess);
    endtask

    // hold the tick channel until every pending reading is back
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (readings_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [11:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_OK_LIMIT: cfg_ok = val[8:0];
            CFG_DANGER_LIMIT: cfg_danger = val[8:0];
            CFG_SAMPLES: cfg_per_avg = val[3:0];
            CFG_WINDOW_MS: cfg_window = val;
            CFG_COOLING_MS: cfg_cooling = val;
            CFG_BLINK_MS: cfg_blink = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic apply_setting(int unsigned ok, int unsigned dg, int unsigned n,
                                 int unsigned w, int unsigned c, int unsigned b);
        write_reg(CFG_OK_LIMIT, 12'(ok));
        write_reg(CFG_DANGER_LIMIT, 12'(dg));
        write_reg(CFG_SAMPLES, 12'(n));
        write_reg(CFG_WINDOW_MS, 12'(w));
        write_reg(CFG_COOLING_MS, 12'(c));
        write_reg(CFG_BLINK_MS, 12'(b));
    endtask

    task automatic cmp_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fails++;
        end
    endtask

    initial
    begin : stall_pattern
        int unsigned left;
        bit hold;
        out_stall = 1'b0;
        left = 0;
        hold = 1'b0;
        forever
        begin
            @(negedge clk);
            if (left == 0)
            begin
                hold = ($urandom_range(0, 3) == 0);
                left = hold ? $urandom_range(1, 12) : $urandom_range(1, 80);
            end
            left--;
            out_stall <= hold;
        end
    end

    initial
    begin : result_check
        status_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid === 1'b1 && !out_stall)
            begin
                if (readings_due.size() == 0)
                begin
                    $error("result beat with no reading pending");
                    fails++;
                end
                else
                begin
                    want = readings_due.pop_front();
                    cmp_field("mode", 16'(want.mode), 16'(mode));
                    cmp_field("green_led", 16'(want.green_led), 16'(green_led));
                    cmp_field("orange_led", 16'(want.orange_led), 16'(orange_led));
                    cmp_field("red_led", 16'(want.red_led), 16'(red_led));
                    cmp_field("blink_run", 16'(want.blink_run), 16'(blink_run));
                    cmp_field("blink_orange", 16'(want.blink_orange), 16'(blink_orange));
                    cmp_field("blink_red", 16'(want.blink_red), 16'(blink_red));
                    cmp_field("tens_segments", 16'(want.tens_segments), 16'(tens_segments));
                    cmp_field("ones_segments", 16'(want.ones_segments), 16'(ones_segments));
                    cmp_field("display_update", 16'(want.display_update),
                              16'(display_update));
                end
            end
        end
    end

    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("thermal_monitor_controller_test: FAIL");
        $finish;
    end

    initial
    begin
        dir_row_t dir_rows [$];
        tick_t t;
        int unsigned sel;
        int unsigned centre;
        int unsigned lo;
        int unsigned hi;
        int unsigned wlen;

        rst_n = 1'b0;
        in_valid = 1'b0;
        sample_valid = 1'b0;
        sample = '0;
        button_edge = 1'b0;
        start_button = 1'b0;
        restart_button = 1'b0;
        cool_button = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        apply_setting(35, 46, 1, 3, 3, 1);

        // ignored while in startup: samples, levels without an edge, restart
        dir_rows.push_back('{tk(0, 0, 0, 0, 0, 0), 1'b1, AT_RESET});
        dir_rows.push_back('{tk(1, 4095, 0, 1, 1, 1), 1'b1, AT_RESET});
        dir_rows.push_back('{tk(1, 0, 1, 0, 1, 0), 1'b1, AT_RESET});
        dir_rows.push_back('{tk(0, 0, 1, 1, 1, 0), 1'b1, CHECK_BLANK});
        dir_rows.push_back('{tk(1, 4095, 0, 0, 0, 0), 1'b1, CHECK_BLANK});
        // full scale average: danger, tens digit too large shows zero
        dir_rows.push_back('{tk(1, 0, 0, 0, 0, 0), 1'b1, DANGER_FULL});
        dir_rows.push_back('{tk(0, 0, 0, 0, 0, 0), 1'b0, '0});
        dir_rows.push_back('{tk(0, 0, 0, 0, 0, 1), 1'b0, '0});
        // evaluation while cooling leaves the mode alone, then a low sum ends danger
        dir_rows.push_back('{tk(1, 0, 0, 0, 0, 0), 1'b0, '0});
        dir_rows.push_back('{tk(1, 0, 0, 0, 0, 0), 1'b0, '0});
        dir_rows.push_back('{tk(0, 0, 0, 0, 0, 0), 1'b0, '0});
        dir_rows.push_back('{tk(1, 328, 0, 0, 0, 0), 1'b0, '0});
        dir_rows.push_back('{tk(1, 12'hAAA, 0, 0, 0, 0), 1'b0, '0});
        dir_rows.push_back('{tk(1, 12'h555, 0, 0, 0, 0), 1'b0, '0});
        dir_rows.push_back('{tk(1, 0, 0, 0, 0, 0), 1'b0, '0});
        // window runs out without the cooling button
        dir_rows.push_back('{tk(0, 0, 0, 0, 0, 0), 1'b0, '0});
        dir_rows.push_back('{tk(0, 0, 0, 0, 0, 0), 1'b0, '0});
        dir_rows.push_back('{tk(0, 0, 0, 0, 0, 0), 1'b0, '0});
        dir_rows.push_back('{tk(1, 4095, 1, 1, 1, 0), 1'b0, '0});
        dir_rows.push_back('{tk(1, 4095, 1, 0, 1, 0), 1'b0, '0});
        dir_rows.push_back('{tk(1, 0, 0, 0, 0, 0), 1'b0, '0});
        // cooling times out into the final blink, then off
        dir_rows.push_back('{tk(0, 0, 0, 0, 0, 1), 1'b0, '0});
        dir_rows.push_back('{tk(0, 0, 0, 0, 0, 0), 1'b0, '0});
        dir_rows.push_back('{tk(0, 0, 0, 0, 0, 0), 1'b0, '0});
        dir_rows.push_back('{tk(0, 0, 0, 0, 0, 0), 1'b0, '0});
        dir_rows.push_back('{tk(0, 0, 0, 0, 0, 0), 1'b0, '0});
        dir_rows.push_back('{tk(0, 0, 1, 0, 1, 0), 1'b0, '0});
        foreach (dir_rows[i])
            send_tick(dir_rows[i].t, dir_rows[i].typed, dir_rows[i].want);
        settle();

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            if (p < 7)
                apply_setting(PLAN[p][0], PLAN[p][1], PLAN[p][2], PLAN[p][3], PLAN[p][4],
                              PLAN[p][5]);
            else
                apply_setting($urandom_range(0, 511), $urandom_range(0, 511),
                              $urandom_range(0, 15), $urandom_range(0, 40),
                              $urandom_range(0, 40), $urandom_range(0, 40));
            gappy = ($urandom_range(0, 3) != 0);
            for (int i = 0; i < TICKS_PER_PHASE; i++)
            begin
                t.sample_valid = 1'($urandom_range(0, 1));
                sel = $urandom_range(0, 3);
                // mix samples near the ok or danger limit with random and extreme ones so every class shows up
                case (sel)
                    0: t.sample = 12'($urandom_range(0, 4095));
                    1, 2:
                    begin
                        centre = ((sel == 1) ? cfg_ok : cfg_danger) * 4095 / 500;
                        if (centre > 4095)
                            centre = 4095;
                        lo = (centre > 24) ? centre - 24 : 0;
                        hi = (centre + 24 > 4095) ? 4095 : centre + 24;
                        t.sample = 12'($urandom_range(lo, hi));
                    end
                    default: t.sample = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
                endcase
                if (mon_mode == MODE_STARTUP || mon_mode == MODE_OFF)
                    t.button_edge = ($urandom_range(0, 3) == 0);
                else
                    t.button_edge = ($urandom_range(0, 24) == 0);
                t.start_button = 1'($urandom_range(0, 1));
                t.restart_button = 1'($urandom_range(0, 1));
                if (mon_mode == MODE_DANGER && mon_phase == PH_WINDOW)
                begin
                    wlen = 32'(nonzero(cfg_window));
                    if (wlen > 50)
                        wlen = 50;
                    t.cool_button = ($urandom_range(0, wlen) == 0);
                end
                else
                    t.cool_button = 1'($urandom_range(0, 1));
                send_tick(t, 1'b0, '0);
                if ($urandom_range(0, 199) == 0)
                    settle();
            end
            settle();
        end

        if (fails == 0)
            $display("thermal_monitor_controller_test: PASS");
        else
            $display("thermal_monitor_controller_test: FAIL");
        $finish;
    end

endmodule
